// ===== hdl/split_frame_reassembler_core_macros.svh =====
// Assertion macros shared by the reassembler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SPLIT_FRAME_REASSEMBLER_CORE_MACROS_SVH
`define SPLIT_FRAME_REASSEMBLER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFR_ASSERT(lbl, clk, rst, prop, msg)
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/sfr_pkg.sv =====
// Shared types and constants for the split frame reassembler.
// No dependencies; used by every module of the block.
package sfr_pkg;

  localparam int FRAME_MAX = 255;
  localparam int BUF_DEPTH = 512;

  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [7:0]  POS_LIMIT     = 8'(FRAME_MAX - 1);
  localparam logic [10:0] DEPTH_LIMIT   = 11'(BUF_DEPTH);
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  // Item kinds carried in the action field
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_START  = 2'd1,
    MODE_APPEND = 2'd2,
    MODE_SINGLE = 2'd3
  } sfr_mode_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       frame_first;
    logic       frame_last;
  } sfr_in_t;

  typedef struct packed {
    logic       write_valid;
    logic [8:0] write_address;
    logic [7:0] write_data;
    logic       deliver;
    logic [8:0] deliver_length;
    logic       partial_dropped;
  } sfr_out_t;

endpackage

// ===== hdl/sfr_in_stage.sv =====
// Input register of the reassembler: holds one accepted item until it is processed.
// Depends on sfr_pkg for the item type.
module sfr_in_stage
  import sfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  sfr_in_t item,
  input  logic    downstream_ready,
  output logic    step,
  output sfr_in_t held_item
);

  logic full;

  // Process the held item whenever the result register can take its result
  assign step       = full && downstream_ready;
  assign item_stall = full && !downstream_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      full <= 1'b1;
    end else if (step) begin
      full <= 1'b0;
    end
  end

  // Load payload on each transfer
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= item;
    end
  end

endmodule

// ===== hdl/sfr_engine.sv =====
// Reassembly state and per-item decision logic of the split frame reassembler.
// Depends on sfr_pkg and the assertion macros header.
`include "split_frame_reassembler_core_macros.svh"
module sfr_engine
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  input  logic        step,
  input  sfr_in_t     cur,
  output sfr_out_t    result
);

  logic [15:0] split_timeout_ticks;

  logic        held_pending, held_pending_next;
  logic [3:0]  held_tag, held_tag_next;
  logic [7:0]  held_length, held_length_next;
  logic [15:0] held_age, held_age_next;
  logic [7:0]  header_latch, header_latch_next;
  logic [7:0]  frame_position, frame_position_next;
  sfr_mode_t   frame_mode, frame_mode_next;
  logic [8:0]  write_base, write_base_next;

  logic        is_tick;
  logic        is_payload;
  logic [9:0]  addr_sum;
  logic        write_ok;
  logic [7:0]  pos_inc;
  logic [15:0] age_inc;
  logic        expire;
  logic        drop_held;

  // Shared decode of the current item
  assign is_tick    = (cur.action == ACT_TICK);
  assign is_payload = (cur.action == ACT_BYTE) && !cur.frame_first
                      && (frame_mode != MODE_IDLE);
  assign addr_sum   = {1'b0, write_base} + {2'b00, frame_position};
  assign write_ok   = (frame_position < POS_LIMIT) && ({1'b0, addr_sum} < DEPTH_LIMIT);
  assign pos_inc    = write_ok ? frame_position + 8'd1 : frame_position;
  assign age_inc    = (held_age == AGE_MAX) ? held_age : held_age + 16'd1;
  assign expire     = is_tick && held_pending && (frame_mode == MODE_IDLE)
                      && (age_inc > split_timeout_ticks);
  assign drop_held  = is_payload && (frame_position == 8'd0)
                      && (frame_mode != MODE_APPEND) && held_pending;

  // Next state
  always_comb begin
    held_pending_next   = held_pending;
    held_tag_next       = held_tag;
    held_length_next    = held_length;
    held_age_next       = held_age;
    header_latch_next   = header_latch;
    frame_position_next = frame_position;
    frame_mode_next     = frame_mode;
    write_base_next     = write_base;
    if (is_tick) begin
      if (held_pending) begin
        held_age_next = age_inc;
      end
      if (expire) begin
        held_pending_next = 1'b0;
        held_length_next  = 8'd0;
      end
    end else if (cur.frame_first) begin
      frame_mode_next     = MODE_IDLE;
      frame_position_next = 8'd0;
      if (!cur.frame_last) begin
        header_latch_next = cur.data_byte;
        if (cur.data_byte[0]) begin
          if (held_pending && (held_tag == cur.data_byte[7:4])) begin
            frame_mode_next = MODE_APPEND;
            write_base_next = {1'b0, held_length};
          end else begin
            frame_mode_next = MODE_START;
            write_base_next = 9'd0;
          end
        end else begin
          frame_mode_next = MODE_SINGLE;
          write_base_next = 9'd0;
        end
      end
    end else if (is_payload) begin
      if (drop_held) begin
        held_pending_next = 1'b0;
        held_length_next  = 8'd0;
      end
      frame_position_next = pos_inc;
      if (cur.frame_last) begin
        case (frame_mode)
          MODE_START: begin
            held_pending_next = 1'b1;
            held_tag_next     = header_latch[7:4];
            held_length_next  = pos_inc;
            held_age_next     = 16'd0;
          end
          MODE_APPEND: begin
            held_pending_next = 1'b0;
            held_length_next  = 8'd0;
          end
          default: begin
          end
        endcase
        frame_mode_next     = MODE_IDLE;
        frame_position_next = 8'd0;
      end
    end
  end

  // Result fields
  always_comb begin
    result = '0;
    result.partial_dropped = drop_held || expire;
    if (is_payload) begin
      if (write_ok) begin
        result.write_valid   = 1'b1;
        result.write_address = addr_sum[8:0];
        result.write_data    = cur.data_byte;
      end
      if (cur.frame_last) begin
        case (frame_mode)
          MODE_APPEND: begin
            result.deliver        = 1'b1;
            result.deliver_length = {1'b0, held_length} + {1'b0, pos_inc};
          end
          MODE_SINGLE: begin
            result.deliver        = 1'b1;
            result.deliver_length = {1'b0, pos_inc};
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      split_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write_enable) begin
      split_timeout_ticks <= cfg_write_data;
    end
  end

  // Advance state once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pending   <= 1'b0;
      held_tag       <= 4'd0;
      held_length    <= 8'd0;
      held_age       <= 16'd0;
      header_latch   <= 8'd0;
      frame_position <= 8'd0;
      frame_mode     <= MODE_IDLE;
      write_base     <= 9'd0;
    end else if (step) begin
      held_pending   <= held_pending_next;
      held_tag       <= held_tag_next;
      held_length    <= held_length_next;
      held_age       <= held_age_next;
      header_latch   <= header_latch_next;
      frame_position <= frame_position_next;
      frame_mode     <= frame_mode_next;
      write_base     <= write_base_next;
    end
  end

  `SFR_ASSERT(a_idle_pos_zero, clk, rst, (frame_mode == MODE_IDLE) |-> (frame_position == 8'd0), "frame position nonzero while idle")
  `SFR_ASSERT(a_empty_len_zero, clk, rst, !held_pending |-> (held_length == 8'd0), "held length kept without a held part")
  `SFR_ASSERT(a_pos_bound, clk, rst, frame_position <= POS_LIMIT, "frame position past frame limit")
  `SFR_ASSERT(a_no_step_hold, clk, rst, !step |=> $stable(frame_mode) && $stable(held_pending), "state moved without a processed item")

endmodule

// ===== hdl/sfr_out_stage.sv =====
// Result register of the reassembler: presents one result until it is transferred.
// Depends on sfr_pkg for the result type.
module sfr_out_stage
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  sfr_out_t next_result,
  output logic     ready,
  output logic     result_valid,
  input  logic     result_stall,
  output sfr_out_t result
);

  // Free when empty or when the current result leaves this cycle
  assign ready = !result_valid || !result_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Capture the new result
  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_result;
    end
  end

endmodule

// ===== hdl/split_frame_reassembler_core.sv =====
// Split frame reassembler: receive bytes and ticks in, buffer writes and deliveries out.
// Usage:
//   Input channel (item_valid / item_stall / item) carries one received byte or one
//   tick per transfer. Frame bytes are marked with frame_first / frame_last; the first
//   byte is the header (tag in bits 7..4, split flag in bit 0).
//   Output channel (result_valid / result_stall / result) returns exactly one result per
//   input transfer: a packet buffer write, a delivery notice and a drop flag.
//   cfg_write_enable / cfg_write_data set the timeout in ticks; write only while idle.
// Timing:
//   One item per cycle sustained while result_stall is low. The input transfer loads
//   the input register, and the item is processed into the result register once that
//   register can take it; result_valid rises when the result register is loaded.
//   When result_stall is held, the result register holds, then the input register
//   fills and item_stall rises; nothing is lost or repeated.
// Reset:
//   rst is synchronous. It empties both registers, clears the held fragment and
//   frame state, and loads the timeout with 2000 ticks.
// Depends on sfr_pkg, sfr_in_stage, sfr_engine and sfr_out_stage.
module split_frame_reassembler_core
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  sfr_in_t     item,
  output logic        result_valid,
  input  logic        result_stall,
  output sfr_out_t    result,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data
);

  logic     out_ready;
  logic     step;
  sfr_in_t  cur;
  sfr_out_t next_result;

  sfr_in_stage u_in (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .downstream_ready (out_ready),
    .step             (step),
    .held_item        (cur)
  );

  sfr_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .step             (step),
    .cur              (cur),
    .result           (next_result)
  );

  sfr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .next_result  (next_result),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
